FILE: rtl/skf_pkg.sv
// Shared types and constants for the scalar Kalman filter.
package skf_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ADDR_W        = 4;

  typedef enum logic [1:0] {
    REG_INIT_EST  = 2'd0,
    REG_INIT_COV  = 2'd1,
    REG_PROC_NS   = 2'd2,
    REG_MEAS_NS   = 2'd3
  } reg_idx_t;

  typedef enum logic {
    ACT_RESTART = 1'b0,
    ACT_FILTER  = 1'b1
  } action_t;

  typedef struct packed {
    logic               action;
    logic signed [31:0] measurement;
  } in_t;

  typedef struct packed {
    logic signed [31:0] estimate;
    logic        [31:0] covariance;
  } out_t;

  typedef struct packed {
    logic signed [31:0] init_estimate;
    logic        [31:0] init_covariance;
    logic        [31:0] process_noise;
    logic        [31:0] measurement_noise;
  } cfg_t;

endpackage

FILE: rtl/scalar_kalman_filter_top.sv
// Top level of the scalar Kalman filter: sequencer, state and channels.
//
//  channel  direction  handshake               payload
//  in_      input      in_valid / in_ready     in_t  {action, measurement}
//  out_     output     out_valid / out_ready   out_t {estimate, covariance}
//  cfg_     input      psel/penable/pwrite     32-bit registers at 4*i
//
// A restart transaction gives its result in the next cycle.
// A filter transaction predicts, then runs the bit-serial divider for the gain,
// then both bit-serial multipliers side by side, then writes back.
// Reset clears estimate and covariance to zero and loads register defaults.
// A result waiting on out_ready holds the next writeback; one transaction at a time.
module scalar_kalman_filter_top import skf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int BW = FRAC_BITS + 1;
  localparam logic [BW-1:0] ONE = BW'(1) << FRAC_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_PRED, S_DIVS, S_DIV, S_MULS, S_MUL, S_WB
  } state_t;

  state_t             state_r;
  cfg_t               cfg;
  logic signed [31:0] x_r;
  logic [31:0]        p_r;
  logic signed [31:0] z_r;
  logic [31:0]        pp_r;
  logic [32:0]        den_r;
  logic signed [32:0] e_r;
  logic [BW-1:0]      gain_r;
  logic               out_valid_r;
  out_t               out_r;

  logic               in_acc;
  logic               wb_fire;
  logic [32:0]        pp_sum;
  logic [31:0]        pp_nxt;
  logic               div_busy;
  logic [BW-1:0]      div_q;
  logic               mul_start;
  logic               mul_e_busy;
  logic               mul_p_busy;
  logic [31:0]        corr;
  logic [31:0]        p_nxt;
  logic signed [31:0] x_nxt;

  skf_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  skf_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk, .rst_n,
    .start (state_r == S_DIVS),
    .num   (pp_r),
    .den   (den_r),
    .busy  (div_busy),
    .quot  (div_q)
  );

  assign mul_start = (state_r == S_MULS);

  skf_mult #(.FRAC_BITS(FRAC_BITS)) u_mul_e (
    .clk, .rst_n,
    .start (mul_start),
    .a     ({{2{e_r[32]}}, e_r}),
    .b     (gain_r),
    .busy  (mul_e_busy),
    .prod  (corr)
  );

  skf_mult #(.FRAC_BITS(FRAC_BITS)) u_mul_p (
    .clk, .rst_n,
    .start (mul_start),
    .a     ({3'b000, pp_r}),
    .b     (ONE - gain_r),
    .busy  (mul_p_busy),
    .prod  (p_nxt)
  );

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_acc   = in_valid && in_ready;
  assign wb_fire  = ((state_r == S_IDLE) && in_acc &&
                     (action_t'(in_data.action) == ACT_RESTART)) ||
                    ((state_r == S_WB) && (!out_valid_r || out_ready));
  assign pp_sum   = {1'b0, p_r} + {1'b0, cfg.process_noise};
  assign pp_nxt   = pp_sum[32] ? 32'hFFFF_FFFF : pp_sum[31:0];
  assign x_nxt    = x_r + $signed(corr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      x_r         <= 32'sd0;
      p_r         <= 32'd0;
    end else begin
      if (out_valid_r && out_ready && !wb_fire) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (action_t'(in_data.action) == ACT_RESTART) begin
              x_r              <= cfg.init_estimate;
              p_r              <= cfg.init_covariance;
              out_r.estimate   <= cfg.init_estimate;
              out_r.covariance <= cfg.init_covariance;
              out_valid_r      <= 1'b1;
            end else begin
              z_r     <= in_data.measurement;
              state_r <= S_PRED;
            end
          end
        end
        S_PRED: begin
          pp_r    <= pp_nxt;
          den_r   <= {1'b0, pp_nxt} + {1'b0, cfg.measurement_noise};
          e_r     <= {z_r[31], z_r} - {x_r[31], x_r};
          state_r <= S_DIVS;
        end
        S_DIVS: state_r <= S_DIV;
        S_DIV: begin
          if (!div_busy) begin
            gain_r  <= div_q;
            state_r <= S_MULS;
          end
        end
        S_MULS: state_r <= S_MUL;
        S_MUL: begin
          if (!mul_e_busy && !mul_p_busy) begin
            state_r <= S_WB;
          end
        end
        S_WB: begin
          // hold until the output register is free
          if (!out_valid_r || out_ready) begin
            x_r              <= x_nxt;
            p_r              <= p_nxt;
            out_r.estimate   <= x_nxt;
            out_r.covariance <= p_nxt;
            out_valid_r      <= 1'b1;
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_idle_units_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!div_busy && !mul_e_busy && !mul_p_busy))
    else $error("arithmetic unit busy while sequencer idle");

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && !div_busy) |-> (div_q <= ONE))
    else $error("gain above 1.0");

  a_filter_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.action) |=> !in_ready)
    else $error("input taken while a filter step is in progress");

  a_cov_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB) |-> (p_nxt <= pp_r))
    else $error("posterior covariance above predicted covariance");
`endif

endmodule

FILE: rtl/skf_regs.sv
// APB register bank holding the filter configuration.
module skf_regs import skf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.init_estimate     <= 32'sd0;
      cfg_r.init_covariance   <= 32'd65536;
      cfg_r.process_noise     <= 32'd655;
      cfg_r.measurement_noise <= 32'd65536;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_INIT_EST: cfg_r.init_estimate     <= pwdata;
        REG_INIT_COV: cfg_r.init_covariance   <= pwdata;
        REG_PROC_NS:  cfg_r.process_noise     <= pwdata;
        REG_MEAS_NS:  cfg_r.measurement_noise <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_INIT_EST: prdata = cfg_r.init_estimate;
      REG_INIT_COV: prdata = cfg_r.init_covariance;
      REG_PROC_NS:  prdata = cfg_r.process_noise;
      REG_MEAS_NS:  prdata = cfg_r.measurement_noise;
    endcase
  end

endmodule

FILE: rtl/skf_divider.sv
// Restoring divider: gain = floor(num * 2^F / den), one quotient bit per cycle.
module skf_divider import skf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [31:0]          num,
  input  logic [32:0]          den,
  output logic                 busy,
  output logic [FRAC_BITS:0]   quot
);

  localparam int QW = FRAC_BITS + 1;
  localparam int CW = $clog2(QW + 1);

  logic [33:0]   rem_r;
  logic [32:0]   den_r;
  logic [QW-1:0] q_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          first_r;
  logic          zero_r;
  logic [33:0]   trial;
  logic          ge;

  // first step compares num itself, since the quotient can reach 1.0
  assign trial = first_r ? rem_r : {rem_r[32:0], 1'b0};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == CW'(1)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r   <= {2'b00, num};
      den_r   <= den;
      q_r     <= '0;
      cnt_r   <= CW'(QW);
      first_r <= 1'b1;
      zero_r  <= (den == 33'd0);
    end else if (busy_r) begin
      rem_r   <= ge ? trial - {1'b0, den_r} : trial;
      q_r     <= {q_r[QW-2:0], ge};
      cnt_r   <= cnt_r - CW'(1);
      first_r <= 1'b0;
    end
  end

  assign busy = busy_r;
  assign quot = zero_r ? '0 : q_r;

endmodule

FILE: rtl/skf_mult.sv
// Shift-add multiplier: signed a times unsigned b, one bit of b per cycle,
// returning the low 32 bits of floor(a * b / 2^F).
module skf_mult import skf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [34:0] a,
  input  logic [FRAC_BITS:0] b,
  output logic               busy,
  output logic [31:0]        prod
);

  localparam int BW = FRAC_BITS + 1;
  localparam int CW = $clog2(BW + 1);

  logic signed [34:0] a_r;
  logic signed [34:0] hi_r;
  logic [BW-1:0]      lo_r;
  logic [BW-1:0]      b_r;
  logic [CW-1:0]      cnt_r;
  logic               busy_r;
  logic signed [34:0] sum;

  assign sum = hi_r + (b_r[0] ? a_r : 35'sd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == CW'(1)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      hi_r  <= '0;
      lo_r  <= '0;
      b_r   <= b;
      cnt_r <= CW'(BW);
    end else if (busy_r) begin
      // shift the partial product right, low bits fall into lo_r
      hi_r  <= sum >>> 1;
      lo_r  <= {sum[0], lo_r[BW-1:1]};
      b_r   <= b_r >> 1;
      cnt_r <= cnt_r - CW'(1);
    end
  end

  assign busy = busy_r;
  assign prod = {hi_r[30:0], lo_r[BW-1]};

endmodule
